[rtl/orthogonal_array_row_gen_top_defines.svh]
// Assertion macros shared by the row generator modules.
// Each macro expects clk and rst_n in scope where it is used.
`ifndef ORTHOGONAL_ARRAY_ROW_GEN_TOP_DEFINES_SVH
`define ORTHOGONAL_ARRAY_ROW_GEN_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define OARG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define OARG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/oarg_pkg.sv]
// Shared constants, types and helper functions of the row generator.
// No dependencies; every other file but the assertion macro header imports this package.
`default_nettype none

package oarg_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_LEVELS  = 31;

  localparam int LVL_W     = 5;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 15;
  localparam int BASIC_W   = 4;
  localparam int COL_IDX_W = $clog2(MAX_COLUMNS);
  localparam int BIT_W     = $clog2(LVL_W);

  // basic columns needed for MAX_COLUMNS at two levels
  localparam int MAX_BASIC = 7;
  localparam int POW_IDX_W = $clog2(MAX_BASIC + 1);
  localparam int DIG_N     = 1 << POW_IDX_W;
  localparam int PROD_W    = ROW_W + LVL_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVELS       = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } cfg_reg_t;

  // clamped level and column counts
  typedef struct packed {
    logic [LVL_W-1:0] q;
    logic [COL_W-1:0] n;
  } oarg_cfg_t;

  // one row job handed from the front to the back
  typedef struct packed {
    logic                             err;
    logic [DIG_N-1:0][LVL_W-1:0]      digits;
  } row_job_t;

  function automatic logic [LVL_W-1:0] clamp_levels(input logic [LVL_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = v;
    if (v < LVL_W'(2)) r = LVL_W'(2);
    if (v > LVL_W'(MAX_LEVELS)) r = LVL_W'(MAX_LEVELS);
    return r;
  endfunction

  function automatic logic [COL_W-1:0] clamp_cols(input logic [COL_W-1:0] v);
    logic [COL_W-1:0] r;
    r = v;
    if (v == '0) r = COL_W'(1);
    if (v > COL_W'(MAX_COLUMNS)) r = COL_W'(MAX_COLUMNS);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/oarg_if.sv]
// Channel interfaces of the row generator: request, result and register write.
// Depends on oarg_pkg for field widths.
`default_nettype none

interface oarg_in_if import oarg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;

  modport source (output valid, output row_index, input ready);
  modport sink   (input valid, input row_index, output ready);
endinterface

interface oarg_out_if import oarg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] entry_value;
  logic [COL_W-1:0] column_index;
  logic             last_entry;
  logic             row_error;

  modport source (output valid, output entry_value, output column_index,
                  output last_entry, output row_error, input ready);
  modport sink   (input valid, input entry_value, input column_index,
                  input last_entry, input row_error, output ready);
endinterface

interface oarg_cfg_if import oarg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/orthogonal_array_row_gen_top.sv]
// Front end: for each row it finds J (J basic columns, J <= 7) by power steps, checks the
// range, extracts 5 quotient bits per digit and hands the job off.
// The back end emits N words, one per cycle while the result sink is ready, with a row
// buffer read before each multiplier group of non-basic columns; an error row gives one word.
// Rows overlap across the two-entry job queue.
// Reset: synchronous active-low rst_n clears control state and sets levels 3, columns 4.
`default_nettype none

module orthogonal_array_row_gen_top import oarg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  oarg_in_if.sink     in_ch,
  oarg_out_if.source  out_ch,
  oarg_cfg_if.sink    cfg_ch
);

  logic [LVL_W-1:0]  levels_r;
  logic [COL_W-1:0]  column_count_r;
  oarg_cfg_t         cfg;

  logic              push, pop, q_full, q_empty;
  row_job_t          push_job, head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r       <= LVL_W'(3);
      column_count_r <= COL_W'(4);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_LEVELS) levels_r <= cfg_ch.data[LVL_W-1:0];
      if (cfg_ch.index == REG_COLUMN_COUNT) column_count_r <= cfg_ch.data[COL_W-1:0];
    end
  end

  assign cfg = {clamp_levels(levels_r), clamp_cols(column_count_r)};

  oarg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  oarg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  oarg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

[rtl/oarg_front.sv]
// Front end: takes a row request, finds J and Q^J, checks the range and
// extracts the base-Q digits of row-1. Depends on oarg_pkg and oarg_if.
`default_nettype none

module oarg_front import oarg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  oarg_in_if.sink      in_ch,
  input  oarg_cfg_t    cfg,
  input  logic         q_full,
  output logic         push,
  output row_job_t     push_job
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_POW  = 5'b00010,
    F_CHK  = 5'b00100,
    F_DIG  = 5'b01000,
    F_PUSH = 5'b10000
  } front_st_t;

  front_st_t             st_r, st_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [ROW_W-1:0]      sum_r, sum_nxt;
  logic [ROW_W-1:0]      rem_r, rem_nxt;
  logic [BASIC_W-1:0]    basic_count_r, basic_count_nxt;
  logic [ROW_W-1:0]      row_limit_r, row_limit_nxt;
  logic [POW_IDX_W-1:0]  dk_r, dk_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [LVL_W-1:0]      dig_r, dig_nxt;
  row_job_t              ent_r, ent_nxt;

  // powers of Q, index 0 is implied
  logic [ROW_W-1:0]      pow_r [1:DIG_N-1];
  logic                  pow_we;
  logic [POW_IDX_W-1:0]  pow_wa;
  logic [ROW_W-1:0]      pow_wd;

  logic [PROD_W-1:0]     prod;
  logic [BASIC_W-1:0]    pidx_full;
  logic [POW_IDX_W-1:0]  pidx;
  logic [ROW_W-1:0]      div;
  logic [PROD_W-1:0]     cand;
  logic                  ge;
  logic [LVL_W-1:0]      dig_cur;
  logic [BASIC_W-1:0]    bc_next;

  assign prod      = PROD_W'(row_limit_r) * PROD_W'(cfg.q);
  assign pidx_full = basic_count_r - BASIC_W'(1) - BASIC_W'(dk_r);
  assign pidx      = pidx_full[POW_IDX_W-1:0];
  assign div       = (pidx == '0) ? ROW_W'(1) : pow_r[pidx];
  assign cand      = PROD_W'(div) << bit_r;
  assign ge        = PROD_W'(rem_r) >= cand;
  assign dig_cur   = dig_r | (ge ? (LVL_W'(1) << bit_r) : '0);
  assign bc_next   = basic_count_r + BASIC_W'(1);

  assign in_ch.ready = (st_r == F_IDLE);
  assign push        = (st_r == F_PUSH) && !q_full;
  assign push_job    = ent_r;

  always_comb begin
    st_nxt          = st_r;
    row_nxt         = row_r;
    sum_nxt         = sum_r;
    rem_nxt         = rem_r;
    basic_count_nxt = basic_count_r;
    row_limit_nxt   = row_limit_r;
    dk_nxt          = dk_r;
    bit_nxt         = bit_r;
    dig_nxt         = dig_r;
    ent_nxt         = ent_r;
    pow_we          = 1'b0;
    pow_wa          = POW_IDX_W'(1);
    pow_wd          = ROW_W'(cfg.q);
    case (st_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          row_nxt         = in_ch.row_index;
          basic_count_nxt = BASIC_W'(1);
          row_limit_nxt   = ROW_W'(cfg.q);
          sum_nxt         = ROW_W'(1);
          pow_we          = 1'b1;
          st_nxt          = F_POW;
        end
      end
      F_POW: begin
        // grow J until (Q^J-1)/(Q-1) covers N
        if (sum_r < ROW_W'(cfg.n)) begin
          sum_nxt         = sum_r + row_limit_r;
          row_limit_nxt   = prod[ROW_W-1:0];
          basic_count_nxt = bc_next;
          pow_we          = 1'b1;
          pow_wa          = bc_next[POW_IDX_W-1:0];
          pow_wd          = prod[ROW_W-1:0];
        end else begin
          st_nxt = F_CHK;
        end
      end
      F_CHK: begin
        ent_nxt.err = (row_r == '0) || (row_r > row_limit_r);
        rem_nxt     = row_r - ROW_W'(1);
        dk_nxt      = '0;
        bit_nxt     = BIT_W'(LVL_W - 1);
        dig_nxt     = '0;
        st_nxt      = ent_nxt.err ? F_PUSH : F_DIG;
      end
      F_DIG: begin
        // one quotient bit per cycle, most significant digit first
        if (ge) rem_nxt = rem_r - cand[ROW_W-1:0];
        if (bit_r == '0) begin
          ent_nxt.digits[dk_r] = dig_cur;
          dig_nxt              = '0;
          bit_nxt              = BIT_W'(LVL_W - 1);
          dk_nxt               = dk_r + POW_IDX_W'(1);
          if (BASIC_W'(dk_r) == basic_count_r - BASIC_W'(1)) st_nxt = F_PUSH;
        end else begin
          dig_nxt = dig_cur;
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      F_PUSH: begin
        if (!q_full) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= F_IDLE;
      basic_count_r <= '0;
      row_limit_r   <= '0;
    end else begin
      st_r          <= st_nxt;
      basic_count_r <= basic_count_nxt;
      row_limit_r   <= row_limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    sum_r <= sum_nxt;
    rem_r <= rem_nxt;
    dk_r  <= dk_nxt;
    bit_r <= bit_nxt;
    dig_r <= dig_nxt;
    ent_r <= ent_nxt;
    if (pow_we) pow_r[pow_wa] <= pow_wd;
  end

endmodule

`default_nettype wire

[rtl/oarg_queue.sv]
// Two-entry job queue between the front and back ends.
// Depends on oarg_pkg and the assertion macro header.
`default_nettype none
`include "orthogonal_array_row_gen_top_defines.svh"

module oarg_queue import oarg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  row_job_t  push_job,
  output logic      full,
  input  logic      pop,
  output row_job_t  head,
  output logic      empty
);

  row_job_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop) count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  `OARG_ASSERT_IMP(a_q_no_overflow, push, !full, "job pushed into a full queue")
  `OARG_ASSERT_IMP(a_q_no_underflow, pop, !empty, "job popped from an empty queue")
  `OARG_ASSERT_NXT(a_q_count_up, push && !pop, count_r == $past(count_r) + QCNT_W'(1), "queue count did not advance on push")

endmodule

`default_nettype wire

[rtl/oarg_back.sv]
// Back end: walks the columns of a row in order, writes each entry into the row buffer and
// drives the result register; an error job gives one error word. Depends on oarg_pkg, oarg_if.
`default_nettype none
`include "orthogonal_array_row_gen_top_defines.svh"

module oarg_back import oarg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  oarg_cfg_t    cfg,
  input  logic         q_empty,
  input  row_job_t     head,
  output logic         pop,
  oarg_out_if.source   out_ch
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_BASIC = 4'b0010,
    B_FETCH = 4'b0100,
    B_NONB  = 4'b1000
  } back_st_t;

  back_st_t              st_r, st_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [POW_IDX_W-1:0]  k_r, k_nxt;
  logic [COL_W-1:0]      bpos_r, bpos_nxt;
  logic [COL_W-1:0]      s_r, s_nxt;
  logic [LVL_W-1:0]      t_r, t_nxt;
  logic [LVL_W-1:0]      ab_r, ab_nxt;
  logic [LVL_W-1:0]      acc_r, acc_nxt;

  logic [LVL_W-1:0]      row_buffer [MAX_COLUMNS];
  logic [LVL_W-1:0]      rd_data_r;
  logic                  rd_en;
  logic [COL_IDX_W-1:0]  rd_addr;
  logic                  wr_en;
  logic [COL_W-1:0]      col_m1;

  logic                  out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]      out_val_r;
  logic [COL_W-1:0]      out_col_r;
  logic                  out_last_r;
  logic                  out_err_r;

  logic                  adv;
  logic                  emit;
  logic [LVL_W-1:0]      e_val_raw;
  logic [COL_W-1:0]      e_col;
  logic                  e_last;
  logic                  e_err;
  logic                  at_last_col;

  function automatic logic [LVL_W-1:0] mod_add(input logic [LVL_W-1:0] a,
                                               input logic [LVL_W-1:0] b,
                                               input logic [LVL_W-1:0] q);
    logic [LVL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, q}) s = s - {1'b0, q};
    return s[LVL_W-1:0];
  endfunction

  assign adv         = !out_valid_r || out_ch.ready;
  assign at_last_col = (col_r == cfg.n);
  assign col_m1      = col_r - COL_W'(1);

  always_comb begin
    st_nxt    = st_r;
    col_nxt   = col_r;
    k_nxt     = k_r;
    bpos_nxt  = bpos_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    ab_nxt    = ab_r;
    acc_nxt   = acc_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    emit      = 1'b0;
    e_val_raw = '0;
    e_col     = col_r;
    e_last    = at_last_col;
    e_err     = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (head.err) begin
            if (adv) begin
              emit   = 1'b1;
              e_col  = '0;
              e_last = 1'b1;
              e_err  = 1'b1;
              pop    = 1'b1;
            end
          end else begin
            col_nxt = COL_W'(1);
            k_nxt   = '0;
            st_nxt  = B_BASIC;
          end
        end
      end
      B_BASIC: begin
        if (adv) begin
          emit      = 1'b1;
          e_val_raw = head.digits[k_r];
          wr_en     = 1'b1;
          ab_nxt    = head.digits[k_r];
          bpos_nxt  = col_r;
          k_nxt     = k_r + POW_IDX_W'(1);
          col_nxt   = col_r + COL_W'(1);
          if (at_last_col) begin
            pop    = 1'b1;
            st_nxt = B_IDLE;
          end else if (col_r != COL_W'(1)) begin
            // start the non-basic group with the first column as multiplier
            s_nxt  = COL_W'(1);
            rd_en  = 1'b1;
            st_nxt = B_FETCH;
          end
        end
      end
      B_FETCH: begin
        acc_nxt = mod_add(rd_data_r, ab_r, cfg.q);
        t_nxt   = LVL_W'(1);
        st_nxt  = B_NONB;
      end
      B_NONB: begin
        if (adv) begin
          emit      = 1'b1;
          e_val_raw = acc_r;
          wr_en     = 1'b1;
          col_nxt   = col_r + COL_W'(1);
          acc_nxt   = mod_add(acc_r, rd_data_r, cfg.q);
          t_nxt     = t_r + LVL_W'(1);
          if (at_last_col) begin
            pop    = 1'b1;
            st_nxt = B_IDLE;
          end else if (t_r == cfg.q - LVL_W'(1)) begin
            if (s_r == bpos_r - COL_W'(1)) begin
              st_nxt = B_BASIC;
            end else begin
              s_nxt   = s_r + COL_W'(1);
              rd_en   = 1'b1;
              rd_addr = s_r[COL_IDX_W-1:0];
              st_nxt  = B_FETCH;
            end
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    k_r    <= k_nxt;
    bpos_r <= bpos_nxt;
    s_r    <= s_nxt;
    t_r    <= t_nxt;
    ab_r   <= ab_nxt;
    acc_r  <= acc_nxt;
    if (emit) begin
      out_val_r  <= e_err ? '0 : e_val_raw + LVL_W'(1);
      out_col_r  <= e_col;
      out_last_r <= e_last;
      out_err_r  <= e_err;
    end
  end

  // row buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) row_buffer[col_m1[COL_IDX_W-1:0]] <= e_val_raw;
    if (rd_en) rd_data_r <= row_buffer[rd_addr];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entry_value  = out_val_r;
  assign out_ch.column_index = out_col_r;
  assign out_ch.last_entry   = out_last_r;
  assign out_ch.row_error    = out_err_r;

  `OARG_ASSERT_IMP(a_head_held, st_r != B_IDLE, !q_empty, "back end busy without a queued job")
  `OARG_ASSERT_IMP(a_entry_range, emit && !e_err, e_val_raw < cfg.q, "entry not below level count")
  `OARG_ASSERT_IMP(a_combo_range, st_r == B_NONB, (s_r != '0) && (s_r < bpos_r) && (t_r != '0) && (t_r < cfg.q), "non-basic column indices out of range")

endmodule

`default_nettype wire

[dv/orthogonal_array_row_gen_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for orthogonal_array_row_gen_top: row requests, register writes,
// and a per-row predictor of the expected words. Depends on oarg_pkg, oarg_if.sv and the RTL.

module orthogonal_array_row_gen_top_tb;
  import oarg_pkg::*;

  localparam int unsigned TIMEOUT_NS = 60_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0] entry_value;
    logic [COL_W-1:0] column_index;
    logic             last_entry;
    logic             row_error;
  } row_word_t;

  logic clk;
  logic rst_n;

  oarg_in_if  in_ch();
  oarg_out_if out_ch();
  oarg_cfg_if cfg_ch();

  orthogonal_array_row_gen_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register copies and row state of the predictor
  logic [LVL_W-1:0] levels_reg = LVL_W'(3);
  logic [COL_W-1:0] columns_reg = COL_W'(4);
  logic [LVL_W-1:0] row_entries [MAX_COLUMNS];

  row_word_t   pending_words[$];
  int unsigned mismatch_count = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_gaps_on = 1'b1;
  int unsigned hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // append one predicted word at the tail
  function automatic void enqueue_word(input row_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic int unsigned eff_levels();
    int unsigned q;
    q = levels_reg;
    if (q < 2) q = 2;
    if (q > MAX_LEVELS) q = MAX_LEVELS;
    return q;
  endfunction

  function automatic int unsigned eff_columns();
    int unsigned n;
    n = columns_reg;
    if (n < 1) n = 1;
    if (n > MAX_COLUMNS) n = MAX_COLUMNS;
    return n;
  endfunction

  // Q^J for the smallest J with (Q^J-1)/(Q-1) >= N
  function automatic int unsigned row_span();
    int unsigned q, n, pw;
    q = eff_levels();
    n = eff_columns();
    pw = q;
    while ((pw - 1) / (q - 1) < n) pw = pw * q;
    return pw;
  endfunction

  task automatic predict_row(input logic [ROW_W-1:0] row);
    int unsigned q, n, pw, r0, grp, b, step_div, x;
    row_word_t w;
    q = eff_levels();
    n = eff_columns();
    pw = row_span();
    if (row == '0 || row > pw) begin
      w = '{entry_value: '0, column_index: '0, last_entry: 1'b1, row_error: 1'b1};
      enqueue_word(w);
      return;
    end
    r0 = row - 1;
    grp = 1;
    // one pass per basic column; non-basic columns mix it with earlier columns
    while (grp < pw) begin
      b = (grp - 1) / (q - 1) + 1;
      step_div = pw / (grp * q);
      if (b > n) break;
      row_entries[b-1] = LVL_W'((r0 / step_div) % q);
      for (int unsigned s = 1; s < b; s++) begin
        for (int unsigned t = 1; t < q; t++) begin
          x = b + (s - 1) * (q - 1) + t;
          if (x <= n)
            row_entries[x-1] = LVL_W'((int'(row_entries[s-1]) * t + row_entries[b-1]) % q);
        end
      end
      grp = grp * q;
    end
    for (int unsigned c = 1; c <= n; c++) begin
      w.entry_value = LVL_W'(row_entries[c-1] + 1);
      w.column_index = COL_W'(c);
      w.last_entry = (c == n);
      w.row_error = 1'b0;
      enqueue_word(w);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    int unsigned span, r;
    span = row_span();
    r = $urandom_range(0, 99);
    if (r < 80) return ROW_W'($urandom_range(1, span));
    if (r < 85) return '0;
    if (r < 90) return ROW_W'(span + 1);
    if (r < 93) return ROW_W'(span);
    return ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
  endfunction

  task automatic send_row(input logic [ROW_W-1:0] row);
    int unsigned gap;
    gap = src_gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.row_index <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_row(row);
  endtask

  // hold valid high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_LEVELS) levels_reg = value[LVL_W-1:0];
    else if (idx == REG_COLUMN_COUNT) columns_reg = value;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] lv, input logic [CFG_DATA_W-1:0] nc,
                            input bit poke_unused);
    if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_LEVELS, lv);
    write_reg(REG_COLUMN_COUNT, nc);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [COL_W-1:0] exp_v,
                             input logic [COL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
    end
  endtask

  // result sink: random stalls plus an optional long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_gaps_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    row_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word expected none got value %0d col %0d last %0b err %0b",
                 $time, out_ch.entry_value, out_ch.column_index, out_ch.last_entry,
                 out_ch.row_error);
      end else begin
        w = pending_words.pop_front();
        check_field("entry_value", COL_W'(w.entry_value), COL_W'(out_ch.entry_value));
        check_field("column_index", w.column_index, out_ch.column_index);
        check_field("last_entry", COL_W'(w.last_entry), COL_W'(out_ch.last_entry));
        check_field("row_error", COL_W'(w.row_error), COL_W'(out_ch.row_error));
      end
    end
  end

  task automatic test_reset_defaults();
    send_row(ROW_W'(1));
    send_row(ROW_W'(5));
    send_row(ROW_W'(row_span()));
    send_row(ROW_W'(row_span() + 1));
    send_row('0);
    wait_idle();
  endtask

  task automatic test_low_clamp();
    // levels and columns below range, plus a write to an unmapped index
    set_config(CFG_DATA_W'(0), CFG_DATA_W'(0), 1'b1);
    send_row(ROW_W'(1));
    send_row(ROW_W'(row_span()));
    send_row(ROW_W'(row_span() + 1));
    wait_idle();
    set_config(CFG_DATA_W'(1), CFG_DATA_W'(2), 1'b0);
    send_row(ROW_W'(row_span()));
    send_row(ROW_W'(row_span() + 1));
    wait_idle();
  endtask

  task automatic test_high_clamp();
    set_config(CFG_DATA_W'(7'h7F), CFG_DATA_W'(7'h7F), 1'b0);
    send_row(ROW_W'(1));
    send_row(ROW_W'(row_span()));
    send_row(ROW_W'(row_span() + 1));
    send_row(ROW_W'((1 << ROW_W) - 1));
    wait_idle();
    // upper data bits set, levels field is 2
    set_config(CFG_DATA_W'(7'h62), CFG_DATA_W'(MAX_COLUMNS), 1'b0);
    send_row(ROW_W'(1));
    send_row(ROW_W'(row_span()));
    send_row(ROW_W'(row_span() + 1));
    wait_idle();
    set_config(CFG_DATA_W'(30), CFG_DATA_W'(MAX_COLUMNS + 1), 1'b0);
    send_row(ROW_W'(row_span()));
    send_row(ROW_W'($urandom_range(1, row_span())));
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_config(CFG_DATA_W'(MAX_LEVELS), CFG_DATA_W'(MAX_COLUMNS), 1'b0);
    src_gaps_on = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (12) send_row(pick_row());
    wait_idle();
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random_rows();
    logic [CFG_DATA_W-1:0] lv, nc;
    int unsigned primes [11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
    for (int phase = 0; phase < 8; phase++) begin
      if ($urandom_range(0, 9) < 6)
        lv = {CFG_DATA_W'($urandom_range(0, 3)) << LVL_W} |
             CFG_DATA_W'(primes[$urandom_range(0, 10)]);
      else
        lv = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: nc = CFG_DATA_W'($urandom_range(1, 13));
        5, 6, 7:       nc = CFG_DATA_W'($urandom_range(0, MAX_COLUMNS));
        default:       nc = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
      endcase
      src_gaps_on = (phase % 3 != 0);
      sink_gaps_on = (phase % 4 != 1);
      set_config(lv, nc, 1'b0);
      repeat (60) send_row(pick_row());
      wait_idle();
    end
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.row_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_low_clamp();
    test_high_clamp();
    test_backpressure();
    test_random_rows();

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("orthogonal_array_row_gen_top_tb OK");
    end else begin
      $display("orthogonal_array_row_gen_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
    $display("orthogonal_array_row_gen_top_tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/oarg_pkg.sv
rtl/oarg_if.sv
rtl/oarg_front.sv
rtl/oarg_queue.sv
rtl/oarg_back.sv
rtl/orthogonal_array_row_gen_top.sv
dv/orthogonal_array_row_gen_top_tb.sv
